>>> design/rgb_to_yuv420_converter_macros.svh
// assertion macros used by the converter checker
// no dependencies; clock and reset are taken from the enclosing scope
`ifndef RGB_TO_YUV420_CONVERTER_MACROS_SVH
`define RGB_TO_YUV420_CONVERTER_MACROS_SVH

// same cycle implication, off during reset
`define RYC_ASSERT_IMP(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("converter check failed");

// next cycle implication, off during reset
`define RYC_ASSERT_NXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("converter check failed");

// next cycle implication, always on
`define RYC_ASSERT_RST(lbl, a, b) \
   lbl: assert property (@(posedge clock) (a) |=> (b)) \
      else $error("converter check failed");

`endif

>>> design/rgb2yuv_pkg.sv
// shared types and constants of the rgb to yuv 4:2:0 converter
// no dependencies
`timescale 1ns / 1ps

package rgb2yuv_pkg;

   localparam int WIDTH_W  = 12;
   localparam int HEIGHT_W = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd1280;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd720;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // bt.601 integer coefficients
   localparam int Y_R  = 66;
   localparam int Y_G  = 129;
   localparam int Y_B  = 25;
   localparam int CB_R = -38;
   localparam int CB_G = -74;
   localparam int CB_B = 112;
   localparam int CR_R = 112;
   localparam int CR_G = -94;
   localparam int CR_B = -18;
   localparam int Y_OFFSET = 16;
   localparam int C_OFFSET = 128;
   localparam int ROUND    = 128;
   localparam int BYTE_MAX = 255;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_word_type;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic [8:0] blue;
      logic [8:0] green;
      logic [8:0] red;
   } pair_sum_type;

   typedef struct packed {
      logic last_col;
      logic last_row;
      logic odd_col;
      logic odd_row;
   } pos_flags_type;

endpackage

>>> design/rgb2yuv_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module rgb2yuv_ram #(
   parameter int DATA_W = 27,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rgb_to_yuv420_converter.sv
// rgb888 to yuv 4:2:0 bt.601 converter, top level; uses rgb2yuv_pkg and rgb2yuv_ram
// each accepted pixel word is registered in the input register, and its result in the result register
// throughput: one pixel per clock while rsp_stall is low, set by the input register, result register and
// the line store's single write and single registered read port
// reset: counters clear, frame size returns to 1280x720; the line store is not cleared
// and each entry is valid once the even row of the frame has written it
`timescale 1ns / 1ps

module rgb_to_yuv420_converter #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  rgb2yuv_pkg::req_word_type               req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output rgb2yuv_pkg::rsp_word_type               rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rgb2yuv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rgb2yuv_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int STORE_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
   localparam int HMAX_W = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP_W = ((WMAX_W > rgb2yuv_pkg::WIDTH_W) ? WMAX_W : rgb2yuv_pkg::WIDTH_W) + 1;
   localparam int HCMP_W = ((HMAX_W > rgb2yuv_pkg::HEIGHT_W) ? HMAX_W : rgb2yuv_pkg::HEIGHT_W) + 1;
   localparam int SUM_W = 18;

   // configuration
   logic [rgb2yuv_pkg::WIDTH_W-1:0]  width_ff;
   logic [rgb2yuv_pkg::HEIGHT_W-1:0] height_ff;

   // position of the next pixel
   logic [COL_W-1:0] col_ff, col_in, col_half;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WCMP_W-1:0] width_eff;
   logic [HCMP_W-1:0] height_eff;
   logic              last_col, last_row;

   // input stage
   logic                          s1_valid_ff, s1_valid_in;
   rgb2yuv_pkg::req_word_type     s1_pix_ff;
   rgb2yuv_pkg::pos_flags_type    s1_flags_ff, s1_flags_in;
   logic [STORE_AW-1:0]           s1_idx_ff, rd_idx;
   logic                          bypass_ff, bypass_in;
   rgb2yuv_pkg::pair_sum_type     bypass_data_ff;
   rgb2yuv_pkg::req_word_type     held_ff;

   // result stage
   logic                          rsp_valid_ff, rsp_valid_in;
   rgb2yuv_pkg::rsp_word_type     rsp_data_ff, rsp_data_in;

   logic accept, advance;

   // line store access
   logic                          wr_en;
   rgb2yuv_pkg::pair_sum_type     wr_sum, ram_rd, store_sum;

   // datapath
   logic [9:0]              tot_r, tot_g, tot_b;
   logic [1:0]              avg_shift;
   logic [8:0]              avg_r, avg_g, avg_b;
   logic                    done;
   logic [16:0]             y_sum;
   logic [8:0]              y_full;
   logic signed [SUM_W-1:0] ar_s, ag_s, ab_s;
   logic signed [SUM_W-1:0] cb_sum, cr_sum, cb_full, cr_full;

   function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] v);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > SUM_W'(rgb2yuv_pkg::BYTE_MAX)) begin
         res = 8'(rgb2yuv_pkg::BYTE_MAX);
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   assign csr_ready = 1'b1;

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // effective frame size and next pixel position
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WCMP_W'(1);
      end else if (WCMP_W'(width_ff) > WCMP_W'(MAX_WIDTH)) begin
         width_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         width_eff = WCMP_W'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = HCMP_W'(1);
      end else if (HCMP_W'(height_ff) > HCMP_W'(MAX_HEIGHT)) begin
         height_eff = HCMP_W'(MAX_HEIGHT);
      end else begin
         height_eff = HCMP_W'(height_ff);
      end
      last_col = (WCMP_W'(col_ff) + WCMP_W'(1)) >= width_eff;
      last_row = (HCMP_W'(row_ff) + HCMP_W'(1)) >= height_eff;
      col_in   = last_col ? '0 : col_ff + COL_W'(1);
      row_in   = row_ff;
      if (last_col) begin
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end
      col_half = col_ff >> 1;
      rd_idx   = col_half[STORE_AW-1:0];
      s1_flags_in.last_col = last_col;
      s1_flags_in.last_row = last_row;
      s1_flags_in.odd_col  = col_ff[0];
      s1_flags_in.odd_row  = row_ff[0];
   end

   // pair sums, block averages and the store write
   always_comb begin
      store_sum = bypass_ff ? bypass_data_ff : ram_rd;
      wr_sum.red   = {1'b0, s1_pix_ff.red}   + (s1_flags_ff.odd_col ? {1'b0, held_ff.red}   : 9'd0);
      wr_sum.green = {1'b0, s1_pix_ff.green} + (s1_flags_ff.odd_col ? {1'b0, held_ff.green} : 9'd0);
      wr_sum.blue  = {1'b0, s1_pix_ff.blue}  + (s1_flags_ff.odd_col ? {1'b0, held_ff.blue}  : 9'd0);
      tot_r = {1'b0, wr_sum.red}   + (s1_flags_ff.odd_row ? {1'b0, store_sum.red}   : 10'd0);
      tot_g = {1'b0, wr_sum.green} + (s1_flags_ff.odd_row ? {1'b0, store_sum.green} : 10'd0);
      tot_b = {1'b0, wr_sum.blue}  + (s1_flags_ff.odd_row ? {1'b0, store_sum.blue}  : 10'd0);
      avg_shift = {1'b0, s1_flags_ff.odd_col} + {1'b0, s1_flags_ff.odd_row};
      avg_r = 9'(tot_r >> avg_shift);
      avg_g = 9'(tot_g >> avg_shift);
      avg_b = 9'(tot_b >> avg_shift);
      done  = (s1_flags_ff.odd_col || s1_flags_ff.last_col)
              && (s1_flags_ff.odd_row || s1_flags_ff.last_row);
      wr_en = advance && (s1_flags_ff.odd_col || s1_flags_ff.last_col) && !s1_flags_ff.odd_row;
      bypass_in = wr_en && (s1_idx_ff == rd_idx);
   end

   // color conversion
   always_comb begin
      y_sum = 17'(s1_pix_ff.red) * 17'(rgb2yuv_pkg::Y_R)
            + 17'(s1_pix_ff.green) * 17'(rgb2yuv_pkg::Y_G)
            + 17'(s1_pix_ff.blue) * 17'(rgb2yuv_pkg::Y_B)
            + 17'(rgb2yuv_pkg::ROUND);
      y_full = 9'(y_sum >> 8) + 9'(rgb2yuv_pkg::Y_OFFSET);
      ar_s = SUM_W'(avg_r);
      ag_s = SUM_W'(avg_g);
      ab_s = SUM_W'(avg_b);
      cb_sum = SUM_W'(rgb2yuv_pkg::CB_R) * ar_s + SUM_W'(rgb2yuv_pkg::CB_G) * ag_s
             + SUM_W'(rgb2yuv_pkg::CB_B) * ab_s + SUM_W'(rgb2yuv_pkg::ROUND);
      cr_sum = SUM_W'(rgb2yuv_pkg::CR_R) * ar_s + SUM_W'(rgb2yuv_pkg::CR_G) * ag_s
             + SUM_W'(rgb2yuv_pkg::CR_B) * ab_s + SUM_W'(rgb2yuv_pkg::ROUND);
      cb_full = (cb_sum >>> 8) + SUM_W'(rgb2yuv_pkg::C_OFFSET);
      cr_full = (cr_sum >>> 8) + SUM_W'(rgb2yuv_pkg::C_OFFSET);
      rsp_data_in.luma         = y_full[7:0];
      rsp_data_in.chroma_valid = done;
      rsp_data_in.cb           = done ? clamp_byte(cb_full) : 8'd0;
      rsp_data_in.cr           = done ? clamp_byte(cr_full) : 8'd0;
      rsp_data_in.frame_end    = s1_flags_ff.last_col && s1_flags_ff.last_row;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rgb2yuv_pkg::WIDTH_RESET;
         height_ff    <= rgb2yuv_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (rgb2yuv_pkg::csr_index_type'(csr_index))
               rgb2yuv_pkg::CSR_FRAME_WIDTH: begin
                  width_ff <= csr_data[rgb2yuv_pkg::WIDTH_W-1:0];
               end
               rgb2yuv_pkg::CSR_FRAME_HEIGHT: begin
                  height_ff <= csr_data[rgb2yuv_pkg::HEIGHT_W-1:0];
               end
            endcase
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (advance && !s1_flags_ff.odd_col && !s1_flags_ff.last_col) begin
            held_ff <= s1_pix_ff;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= req_data;
         s1_flags_ff    <= s1_flags_in;
         s1_idx_ff      <= rd_idx;
         bypass_ff      <= bypass_in;
         bypass_data_ff <= wr_sum;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // even row pair sums, one entry per column pair
   rgb2yuv_ram #(
      .DATA_W ($bits(rgb2yuv_pkg::pair_sum_type)),
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (STORE_AW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (wr_sum),
      .rd_en   (accept),
      .rd_addr (rd_idx),
      .rd_data (ram_rd)
   );

endmodule

>>> design/rgb2yuv_checker.sv
// port level checks of the converter, bound to the top level
// uses rgb2yuv_pkg and rgb_to_yuv420_converter_macros.svh
`timescale 1ns / 1ps
`include "rgb_to_yuv420_converter_macros.svh"

module rgb2yuv_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rgb2yuv_pkg::rsp_word_type rsp_data
);

   // last pixel of a frame always closes a block
   `RYC_ASSERT_IMP(frame_end_closes_block, rsp_valid && rsp_data.frame_end, rsp_data.chroma_valid)

   // no chroma word means zero chroma fields
   `RYC_ASSERT_IMP(chroma_zero_when_idle, rsp_valid && !rsp_data.chroma_valid, rsp_data.cb == 8'd0 && rsp_data.cr == 8'd0)

   // a stalled result word holds
   `RYC_ASSERT_NXT(rsp_hold_on_stall, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // pipeline is empty after reset
   `RYC_ASSERT_RST(empty_after_reset, reset, !rsp_valid && !req_stall)

endmodule

bind rgb_to_yuv420_converter rgb2yuv_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
